>>> hdl/bped_pkg.sv
// ----------------------------------------------------------------------------
// Button press event detector package
// Event codes, register map and reset values shared by the block's files.
// ----------------------------------------------------------------------------
package bped_pkg;

   typedef enum logic [2:0] {
      EV_IDLE     = 3'd0,
      EV_PRESSED  = 3'd1,
      EV_RELEASED = 3'd2,
      EV_LONG     = 3'd3,
      EV_SLOW     = 3'd4,
      EV_FAST     = 3'd5
   } event_type;

   localparam int unsigned CSR_AW = 4;

   typedef enum logic [1:0] {
      REG_LONG_PRESS  = 2'd0,
      REG_FAST_AFTER  = 2'd1,
      REG_SLOW_REPEAT = 2'd2,
      REG_FAST_REPEAT = 2'd3
   } reg_index_type;

   localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
   localparam logic [15:0] FAST_AFTER_RST  = 16'd3000;
   localparam logic [15:0] SLOW_REPEAT_RST = 16'd500;
   localparam logic [15:0] FAST_REPEAT_RST = 16'd100;

endpackage

>>> hdl/bped_req_if.sv
// ----------------------------------------------------------------------------
// Button sample channel
// Valid/ready channel carrying one button sample or clear command per word.
// ----------------------------------------------------------------------------
interface bped_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic        level;
   logic [31:0] now_ms;

   modport source (output valid, cmd, level, now_ms, input ready);
   modport sink   (input valid, cmd, level, now_ms, output ready);
endinterface

>>> hdl/bped_rsp_if.sv
// ----------------------------------------------------------------------------
// Button event channel
// Valid/ready channel carrying one detected event and the held flag per word.
// ----------------------------------------------------------------------------
interface bped_rsp_if import bped_pkg::*;;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       held;

   modport source (output valid, event_res, held, input ready);
   modport sink   (input valid, event_res, held, output ready);
endinterface

>>> hdl/button_press_event_detector_core.sv
// ----------------------------------------------------------------------------
// Button press event detector core
// Debounce, press/release, long press and auto-repeat detection on a stream
// of timestamped button samples, with an APB-style register port.
// ----------------------------------------------------------------------------
// An accepted sample word goes through the input register, then the result
// register. Throughput: one word per clock while rsp.ready allows; the hold
// state update is a single pass of subtract/compare logic between the two.
// Reset: synchronous, clears both stages and the hold state, loads the
// register defaults; first word may be accepted the cycle after reset drops.
// ----------------------------------------------------------------------------
module button_press_event_detector_core import bped_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bped_req_if.sink          req,
   bped_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // configuration registers
   logic [15:0] long_press_ff, fast_after_ff, slow_repeat_ff, fast_repeat_ff;
   reg_index_type csr_idx;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff  <= LONG_PRESS_RST;
         fast_after_ff  <= FAST_AFTER_RST;
         slow_repeat_ff <= SLOW_REPEAT_RST;
         fast_repeat_ff <= FAST_REPEAT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LONG_PRESS:  long_press_ff  <= csr_pwdata[15:0];
            REG_FAST_AFTER:  fast_after_ff  <= csr_pwdata[15:0];
            REG_SLOW_REPEAT: slow_repeat_ff <= csr_pwdata[15:0];
            REG_FAST_REPEAT: fast_repeat_ff <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LONG_PRESS:  csr_prdata = {16'd0, long_press_ff};
         REG_FAST_AFTER:  csr_prdata = {16'd0, fast_after_ff};
         REG_SLOW_REPEAT: csr_prdata = {16'd0, slow_repeat_ff};
         REG_FAST_REPEAT: csr_prdata = {16'd0, fast_repeat_ff};
      endcase
   end

   // pipeline control
   logic        in_valid_ff, out_valid_ff;
   logic        in_cmd_ff, in_level_ff;
   logic [31:0] in_now_ff;
   logic        out_free, fire;

   assign out_free  = ~out_valid_ff | rsp.ready;
   assign fire      = in_valid_ff & out_free;
   assign req.ready = ~reset & (~in_valid_ff | out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready & req.valid) begin
         in_cmd_ff   <= req.cmd;
         in_level_ff <= req.level;
         in_now_ff   <= req.now_ms;
      end
   end

   // hold state
   logic        prev_level_ff, prev_level_in;
   logic        is_held_ff, is_held_in;
   logic        long_seen_ff, long_seen_in;
   logic [31:0] press_start_ff, press_start_in;
   logic [31:0] repeat_start_ff, repeat_start_in;
   event_type   ev;
   logic [31:0] hold, since;

   assign hold  = in_now_ff - press_start_ff;
   assign since = in_now_ff - repeat_start_ff;

   always_comb begin
      prev_level_in   = prev_level_ff;
      is_held_in      = is_held_ff;
      long_seen_in    = long_seen_ff;
      press_start_in  = press_start_ff;
      repeat_start_in = repeat_start_ff;
      ev              = EV_IDLE;
      priority if (in_cmd_ff) begin
         is_held_in      = 1'b0;
         long_seen_in    = 1'b0;
         press_start_in  = '0;
         repeat_start_in = '0;
      end else if (in_level_ff != prev_level_ff) begin
         // one-sample debounce
         prev_level_in = in_level_ff;
      end else if (!in_level_ff && !is_held_ff) begin
         is_held_in      = 1'b1;
         long_seen_in    = 1'b0;
         press_start_in  = in_now_ff;
         repeat_start_in = in_now_ff;
         ev              = EV_PRESSED;
      end else if (in_level_ff && is_held_ff) begin
         is_held_in   = 1'b0;
         long_seen_in = 1'b0;
         ev           = EV_RELEASED;
      end else if (!in_level_ff) begin
         // held: long press wins over any repeat
         priority if (!long_seen_ff && hold >= {16'd0, long_press_ff}) begin
            long_seen_in = 1'b1;
            ev           = EV_LONG;
         end else if (hold >= {16'd0, fast_after_ff}) begin
            if (since >= {16'd0, fast_repeat_ff}) begin
               repeat_start_in = in_now_ff;
               ev              = EV_FAST;
            end
         end else if (long_seen_ff && since >= {16'd0, slow_repeat_ff}) begin
            repeat_start_in = in_now_ff;
            ev              = EV_SLOW;
         end else begin
            // nothing due yet
         end
      end else begin
         // stable high while released: idle
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff   <= 1'b1;
         is_held_ff      <= 1'b0;
         long_seen_ff    <= 1'b0;
         press_start_ff  <= '0;
         repeat_start_ff <= '0;
      end else if (fire) begin
         prev_level_ff   <= prev_level_in;
         is_held_ff      <= is_held_in;
         long_seen_ff    <= long_seen_in;
         press_start_ff  <= press_start_in;
         repeat_start_ff <= repeat_start_in;
      end
   end

   // result register
   logic [2:0] out_event_ff;
   logic       out_held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_event_ff <= ev;
         out_held_ff  <= is_held_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.event_res = out_event_ff;
   assign rsp.held      = out_held_ff;

endmodule

>>> hdl/bped_checker.sv
// ----------------------------------------------------------------------------
// Button press event detector checker
// Port-level assertions on the event channel, bound to the core.
// ----------------------------------------------------------------------------
module bped_checker import bped_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic       rsp_held
);

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= EV_FAST)
      else $error("undefined event code");

   a_press_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_PRESSED || rsp_event_res == EV_LONG ||
                    rsp_event_res == EV_SLOW || rsp_event_res == EV_FAST)
      |-> rsp_held)
      else $error("press-type event without held");

   a_release_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_RELEASED |-> !rsp_held)
      else $error("release event with held set");

endmodule

bind button_press_event_detector_core bped_checker u_bped_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_event_res (rsp.event_res),
   .rsp_held      (rsp.held)
);
